/* hdl/tlbpt_pkg.sv */
// tlbpt_pkg: constants, types and state codes for the tlb page table translator
// no dependencies
package tlbpt_pkg;

  localparam int TlbEntries = 16;
  localparam int MaxFrames  = 256;
  localparam int OffBits    = 8;
  localparam int TlbIdxW    = $clog2(TlbEntries);
  localparam int FrmIdxW    = $clog2(MaxFrames);
  localparam int FrmCntW    = FrmIdxW + 1;
  localparam int StampW     = 32;
  localparam int CntW       = 32;
  localparam int PageW      = 8;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_LRU    = 7'b0000100,
    ST_PLACE  = 7'b0001000,
    ST_STAMP  = 7'b0010000,
    ST_OUT    = 7'b0100000,
    ST_WAIT   = 7'b1000000
  } tlbpt_state_t;

endpackage

/* hdl/tlbpt_ram.sv */
// tlbpt_ram: generic single-port synchronous ram with registered read
// no dependencies
module tlbpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/tlb_page_table_translator_lru_unit.sv */
// tlb_page_table_translator_lru_unit: top level of the address translator
// depends on tlbpt_pkg and tlbpt_ram
//
// in_ channel: one 16-bit logical address per transaction (page 15:8, offset 7:0).
// out_ channel: one translation per transaction with frame, tlb hit, page fault
// and saturating fault and hit counts.
// cfg_ port: apb-style, register 0 at address 0 is frames_in_use (9 bits).
// one transaction is handled at a time. a miss scans the frame table memory one
// entry per cycle, and a fault with all frames used scans it again for the lru
// victim. the tlb (16 entries) sits in flip-flops and is searched combinationally.
// reset clears tlb and frame valid bits, the fill pointer, free frame pointer,
// access clock and counters; frame_page and stamp memories need no clearing.
// the result is held in an output register; while the receiver stalls no new
// transaction is taken.
module tlb_page_table_translator_lru_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_logical_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_physical_address,
  output logic [7:0]  out_frame_number,
  output logic        out_tlb_hit,
  output logic        out_page_fault,
  output logic [31:0] out_fault_count,
  output logic [31:0] out_hit_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tlbpt_pkg::*;

  tlbpt_state_t state_r, state_nxt;

  logic [8:0]             fiu_r;
  logic [TlbEntries-1:0]  tlbv_r;
  logic [PageW-1:0]       tlbp_r [TlbEntries];
  logic [FrmIdxW-1:0]     tlbf_r [TlbEntries];
  logic [TlbIdxW-1:0]     fill_r;
  logic [MaxFrames-1:0]   fv_r;
  logic [FrmCntW-1:0]     nff_r;
  logic [StampW-1:0]      clk_cnt_r;
  logic [CntW-1:0]        faults_r, hits_r;
  logic [15:0]            addr_r;
  logic [FrmIdxW-1:0]     frame_r;
  logic                   hit_r, fault_r;
  logic [FrmCntW-1:0]     idx_r;       // scan index, one wider for end test
  logic [FrmCntW-1:0]     lim_r;
  logic [FrmIdxW-1:0]     best_r;
  logic [StampW-1:0]      best_age_r;
  logic                   found_r;
  logic                   rd_pend_r;   // memory data valid for idx_r-1

  // memories
  logic                   pg_we, st_we;
  logic [FrmIdxW-1:0]     mem_addr;
  logic [PageW-1:0]       pg_rdata;
  logic [StampW-1:0]      st_rdata;
  logic [FrmIdxW-1:0]     prev_idx;

  tlbpt_ram #(.Width(PageW), .Depth(MaxFrames)) u_page_ram (
    .clk(clk), .we(pg_we), .addr(mem_addr), .wdata(addr_r[15:8]), .rdata(pg_rdata)
  );
  tlbpt_ram #(.Width(StampW), .Depth(MaxFrames)) u_stamp_ram (
    .clk(clk), .we(st_we), .addr(mem_addr), .wdata(clk_cnt_r), .rdata(st_rdata)
  );

  assign prev_idx = FrmIdxW'(idx_r - FrmCntW'(1));

  // tlb search, lowest matching entry
  logic                 tlb_hit_c;
  logic [FrmIdxW-1:0]   tlb_frm_c;
  always_comb begin
    tlb_hit_c = 1'b0;
    tlb_frm_c = '0;
    for (int i = TlbEntries - 1; i >= 0; i--) begin
      if (tlbv_r[i] && tlbp_r[i] == in_logical_address[15:8]) begin
        tlb_hit_c = 1'b1;
        tlb_frm_c = tlbf_r[i];
      end
    end
  end

  logic [FrmCntW-1:0] lim_c;
  always_comb begin
    if (fiu_r == 9'd0) lim_c = FrmCntW'(1);
    else if ({1'b0, fiu_r} > 10'(MaxFrames)) lim_c = FrmCntW'(MaxFrames);
    else lim_c = FrmCntW'(fiu_r);
  end

  logic [StampW-1:0] age_c;
  assign age_c = clk_cnt_r - st_rdata;

  assign in_ready   = (state_r == ST_IDLE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {23'd0, fiu_r};

  always_comb begin
    state_nxt = state_r;
    mem_addr  = idx_r[FrmIdxW-1:0];
    pg_we     = 1'b0;
    st_we     = 1'b0;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = tlb_hit_c ? ST_STAMP : ST_SCAN;
      ST_SCAN: begin
        if (rd_pend_r && fv_r[prev_idx] && pg_rdata == addr_r[15:8])
          state_nxt = ST_STAMP;
        else if (idx_r == FrmCntW'(MaxFrames) && rd_pend_r)
          state_nxt = (nff_r < lim_r) ? ST_PLACE : ST_LRU;
      end
      ST_LRU: if (rd_pend_r && idx_r == lim_r) state_nxt = ST_PLACE;
      ST_PLACE: begin
        mem_addr  = frame_r;
        pg_we     = 1'b1;
        state_nxt = ST_STAMP;
      end
      ST_STAMP: begin
        mem_addr  = frame_r;
        st_we     = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT:  state_nxt = ST_WAIT;
      ST_WAIT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fiu_r     <= 9'd256;
      tlbv_r    <= '0;
      fill_r    <= '0;
      fv_r      <= '0;
      nff_r     <= '0;
      clk_cnt_r <= '0;
      faults_r  <= '0;
      hits_r    <= '0;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0)
        fiu_r <= cfg_pwdata[8:0];
      case (state_r)
        ST_IDLE: begin
          addr_r    <= in_logical_address;
          idx_r     <= '0;
          rd_pend_r <= 1'b0;
          found_r   <= 1'b0;
          lim_r     <= lim_c;
          hit_r     <= tlb_hit_c;
          fault_r   <= 1'b0;
          frame_r   <= tlb_frm_c;
          if (in_valid && tlb_hit_c && hits_r != '1) hits_r <= hits_r + 1'b1;
        end
        ST_SCAN: begin
          if (rd_pend_r && fv_r[prev_idx] && pg_rdata == addr_r[15:8]) begin
            frame_r <= prev_idx;
          end else if (idx_r == FrmCntW'(MaxFrames) && rd_pend_r) begin
            fault_r <= 1'b1;
            if (faults_r != '1) faults_r <= faults_r + 1'b1;
            idx_r     <= '0;
            rd_pend_r <= 1'b0;
            if (nff_r < lim_r) begin
              frame_r <= nff_r[FrmIdxW-1:0];
              nff_r   <= nff_r + 1'b1;
            end
          end else begin
            if (idx_r != FrmCntW'(MaxFrames)) idx_r <= idx_r + 1'b1;
            rd_pend_r <= 1'b1;
          end
        end
        ST_LRU: begin
          if (rd_pend_r && fv_r[prev_idx] && (!found_r || age_c > best_age_r)) begin
            best_r     <= prev_idx;
            best_age_r <= age_c;
            found_r    <= 1'b1;
          end
          if (rd_pend_r && idx_r == lim_r) begin
            if (fv_r[prev_idx] && (!found_r || age_c > best_age_r)) frame_r <= prev_idx;
            else frame_r <= found_r ? best_r : '0;
          end else begin
            idx_r     <= idx_r + 1'b1;
            rd_pend_r <= 1'b1;
          end
        end
        ST_PLACE: begin
          fv_r[frame_r] <= 1'b1;
          for (int i = 0; i < TlbEntries; i++)
            if (tlbf_r[i] == frame_r) tlbv_r[i] <= 1'b0;
        end
        ST_STAMP: begin
          clk_cnt_r <= clk_cnt_r + 1'b1;
          if (!hit_r) begin
            tlbv_r[fill_r] <= 1'b1;
            fill_r         <= fill_r + 1'b1;
          end
        end
        ST_OUT:  out_valid <= 1'b1;
        ST_WAIT: if (out_ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_STAMP && !hit_r) begin
      tlbp_r[fill_r] <= addr_r[15:8];
      tlbf_r[fill_r] <= frame_r;
    end
  end

  assign out_physical_address = {frame_r, addr_r[7:0]};
  assign out_frame_number     = frame_r;
  assign out_tlb_hit          = hit_r;
  assign out_page_fault       = fault_r;
  assign out_fault_count      = faults_r;
  assign out_hit_count        = hits_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_hit_nofault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tlb_hit && out_page_fault)) else $error("hit and fault");
  a_nff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nff_r <= FrmCntW'(MaxFrames)) else $error("free pointer overflow");
endmodule

/* bench/tlb_page_table_translator_lru_unit_test.sv */
// tlb_page_table_translator_lru_unit_test: self-checking bench for the address translator
// depends on tlbpt_pkg and the translator rtl; predicts each translation and checks the out_ channel
module tlb_page_table_translator_lru_unit_test;
  import tlbpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CfgFramesInUse = 0;
  localparam int IdleLimit      = 20000;
  localparam int DrainCycles    = 600;

  typedef struct packed {
    logic [15:0] phys;
    logic [7:0]  frame;
    logic        hit;
    logic        fault;
    logic [31:0] faults;
    logic [31:0] hits;
  } xlate_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_logical_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_physical_address;
  logic [7:0]  out_frame_number;
  logic        out_tlb_hit;
  logic        out_page_fault;
  logic [31:0] out_fault_count;
  logic [31:0] out_hit_count;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tlb_page_table_translator_lru_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // translator state mirror
  logic [PageW-1:0]  tlb_pg   [TlbEntries];
  logic [FrmIdxW-1:0] tlb_frm [TlbEntries];
  logic              tlb_ok   [TlbEntries];
  logic [TlbIdxW-1:0] tlb_ptr;
  logic [PageW-1:0]  frm_pg   [MaxFrames];
  logic              frm_ok   [MaxFrames];
  logic [StampW-1:0] frm_stamp[MaxFrames];
  logic [FrmCntW-1:0] free_frame;
  logic [StampW-1:0] clock_now;
  logic [CntW-1:0]   fault_total;
  logic [CntW-1:0]   hit_total;
  logic [8:0]        frames_cfg;

  xlate_t expected_q[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     hold_off_req = 1'b0;
  bit     quiet_mode = 1'b0;

  function automatic xlate_t translate(input logic [15:0] la);
    logic [7:0]  page;
    logic [7:0]  frame;
    logic        hit;
    logic        fault;
    logic        found;
    int          limit;
    logic [31:0] age;
    logic [31:0] best_age;
    xlate_t      r;
    page = la[15:8];
    frame = '0;
    hit = 1'b0;
    fault = 1'b0;
    found = 1'b0;
    for (int i = 0; i < TlbEntries; i++) begin
      if (!hit && tlb_ok[i] && tlb_pg[i] == page) begin
        frame = tlb_frm[i];
        hit = 1'b1;
      end
    end
    if (!hit) begin
      for (int i = 0; i < MaxFrames; i++) begin
        if (!found && frm_ok[i] && frm_pg[i] == page) begin
          frame = i[7:0];
          found = 1'b1;
        end
      end
      if (!found) begin
        limit = (frames_cfg == 0) ? 1 : (frames_cfg > MaxFrames) ? MaxFrames : int'(frames_cfg);
        fault = 1'b1;
        if (int'(free_frame) < limit) begin
          frame = free_frame[7:0];
          free_frame = free_frame + 1'b1;
        end else begin
          // oldest stamp wins, lowest frame on a tie
          found = 1'b0;
          best_age = '0;
          for (int i = 0; i < limit; i++) begin
            if (frm_ok[i]) begin
              age = clock_now - frm_stamp[i];
              if (!found || age > best_age) begin
                frame = i[7:0];
                best_age = age;
                found = 1'b1;
              end
            end
          end
        end
        for (int i = 0; i < TlbEntries; i++)
          if (tlb_ok[i] && tlb_frm[i] == frame) tlb_ok[i] = 1'b0;
        frm_pg[frame] = page;
        frm_ok[frame] = 1'b1;
        if (fault_total != '1) fault_total = fault_total + 1'b1;
      end
      tlb_pg[tlb_ptr] = page;
      tlb_frm[tlb_ptr] = frame;
      tlb_ok[tlb_ptr] = 1'b1;
      tlb_ptr = tlb_ptr + 1'b1;
    end else if (hit_total != '1) begin
      hit_total = hit_total + 1'b1;
    end
    frm_stamp[frame] = clock_now;
    clock_now = clock_now + 1'b1;
    r.phys = {frame, la[7:0]};
    r.frame = frame;
    r.hit = hit;
    r.fault = fault;
    r.faults = fault_total;
    r.hits = hit_total;
    return r;
  endfunction

  task automatic send_address(input logic [15:0] la);
    int gap;
    gap = 0;
    if (!quiet_mode) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: gap = $urandom_range(1, 3);
        4:          gap = $urandom_range(15, 60);
        default:    gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_logical_address <= la;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(translate(la));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // apb write then readback, only while the translator is idle
  task automatic set_frames(input logic [8:0] value);
    logic [31:0] data;
    wait_drained();
    data = {23'($urandom_range(0, 32'h7F_FFFF)), value};
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 1'(CfgFramesInUse);
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    frames_cfg = value;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[8:0] !== value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("frames_in_use readback: expected %0d actual %0d", value, cfg_prdata[8:0]);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // mostly a small working set so the tlb and the frame table both get hits
  function automatic logic [15:0] pick_address(input int base, input int span);
    logic [7:0] page;
    if ($urandom_range(0, 9) < 7) page = 8'((base + $urandom_range(0, span - 1)) % 256);
    else page = 8'($urandom_range(0, 255));
    return {page, 8'($urandom_range(0, 255))};
  endfunction

  task automatic test_directed();
    logic [15:0] list[$];
    list = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0012, 16'h5AA5, 16'hA55A};
    foreach (list[i]) send_address(list[i]);
    // seventeen fresh pages wrap the tlb fill pointer, then page 0 comes from the frame table
    for (int p = 1; p <= 17; p++) send_address({8'(p), 8'(p * 7)});
    send_address(16'h0033);
  endtask

  task automatic test_single_frame();
    set_frames(9'd1);
    // every new page evicts frame 0 and must kill its tlb entries
    for (int i = 0; i < 12; i++) send_address({8'(i % 3 + 40), 8'($urandom)});
    set_frames(9'd0);
    for (int i = 0; i < 12; i++) send_address(pick_address(60, 3));
  endtask

  task automatic test_lru(input logic [8:0] frames, input int count, input int span);
    int base;
    set_frames(frames);
    base = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) send_address(pick_address(base, span));
  endtask

  task automatic test_lowered_limit();
    set_frames(9'd256);
    for (int i = 0; i < 40; i++) send_address(pick_address(100, 40));
    // frames above the new limit stay findable but are never chosen again
    set_frames(9'd5);
    for (int i = 0; i < 80; i++) send_address(pick_address(90, 60));
    set_frames(9'd511);
    for (int i = 0; i < 80; i++) send_address(pick_address(0, 256));
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off_req = 1'b1;
        for (int i = 0; i < 30; i++) send_address(pick_address(20, 10));
      end
    join
    // sender idles until every transaction has come back
    wait_drained();
    quiet_mode = 1'b1;
    for (int i = 0; i < 60; i++) send_address(pick_address(20, 12));
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_mix();
    logic [8:0] settings[$];
    settings = '{9'd2, 9'd7, 9'd16, 9'd255, 9'd256, 9'd300};
    for (int r = 0; r < 8; r++) begin
      if (r < settings.size()) set_frames(settings[r]);
      else set_frames(9'($urandom_range(1, 40)));
      for (int i = 0; i < 118; i++) send_address(pick_address(8 * r, 24));
    end
  endtask

  // result receiver
  initial begin
    int gap;
    int sel;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end
      sel = $urandom_range(0, 49);
      if (quiet_mode) gap = 0;
      else if (sel < 8) gap = $urandom_range(1, 3);
      else if (sel == 8) gap = $urandom_range(20, 80);
      else gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    xlate_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: phys %h", out_physical_address);
      end else begin
        want = expected_q.pop_front();
        if (out_physical_address !== want.phys || out_frame_number !== want.frame ||
            out_tlb_hit !== want.hit || out_page_fault !== want.fault ||
            out_fault_count !== want.faults || out_hit_count !== want.hits) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected phys %h frame %0d hit %b fault %b faults %0d ",
                      "hits %0d, actual phys %h frame %0d hit %b fault %b faults %0d hits %0d"},
                     want.phys, want.frame, want.hit, want.fault, want.faults, want.hits,
                     out_physical_address, out_frame_number, out_tlb_hit, out_page_fault,
                     out_fault_count, out_hit_count);
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (tlb_ok[i]) tlb_ok[i] = 1'b0;
    foreach (frm_ok[i]) frm_ok[i] = 1'b0;
    tlb_ptr = '0;
    free_frame = '0;
    clock_now = '0;
    fault_total = '0;
    hit_total = '0;
    frames_cfg = 9'd256;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_single_frame();
    test_lru(9'd4, 60, 6);
    test_lowered_limit();
    test_backpressure();
    test_random_mix();
    test_lru(9'd256, 60, 256);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/tlbpt_pkg.sv
hdl/tlbpt_ram.sv
hdl/tlb_page_table_translator_lru_unit.sv
bench/tlb_page_table_translator_lru_unit_test.sv
